@@ src/dmvu_pkg.sv @@
// Shared types and constants for the dot-matrix VU meter.
// No dependencies.
package dmvu_pkg;

  localparam int COLUMNS = 7;
  localparam int MIN_H = 4;
  localparam int MAX_H = 24;

  typedef struct packed {
    logic       clear;
    logic       tgt_en;
    logic       update;
    logic       load;
    logic       shift;
    logic       wobble_en;
    logic [6:0] level;
    logic [2:0] phase;
  } cell_ctl_t;

  // Bell profile divided by 20: 40,60,80,100,80,60,40.
  function automatic logic [2:0] bell_step(input int col);
    logic [2:0] s;
    case (col)
      0, 6:    s = 3'd2;
      1, 5:    s = 3'd3;
      2, 4:    s = 3'd4;
      default: s = 3'd5;
    endcase
    return s;
  endfunction

endpackage

@@ src/dmvu_cell.sv @@
// One meter column: bar height, target and row count, plus a shift stage for results.
// Depends on dmvu_pkg.
module dmvu_cell
  import dmvu_pkg::*;
#(
  parameter int COL      = 0,
  parameter int DOT_ROWS = 5
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic [2:0] rows_in,
  output logic [2:0] rows_out
);

  localparam logic [2:0] STEP   = bell_step(COL);
  localparam logic [2:0] OFFSET = 3'((3 * COL) % 7);
  localparam int MAX_M = (MAX_H - MIN_H) * (DOT_ROWS - 1) + (MAX_H - MIN_H) / 2;
  localparam int MW = $clog2(MAX_M + 1);
  localparam int YW = MW - 2;
  localparam int PW = YW + 8;

  logic [4:0]    bar;
  logic [4:0]    bar_next;
  logic [4:0]    target;
  logic [4:0]    target_next;
  logic [8:0]    scaled;
  logic [20:0]   lift_prod;
  logic [4:0]    lift;
  logic [3:0]    phase_sum;
  logic [2:0]    wobble;
  logic [4:0]    target_raw;
  logic [4:0]    target_sub;
  logic [4:0]    rise;
  logic [4:0]    fall_num;
  logic [7:0]    fall_prod;
  logic [4:0]    height_off;
  logic [MW-1:0] mval;
  logic [YW-1:0] yval;
  logic [PW-1:0] qprod;
  logic [4:0]    rows_full;
  logic [2:0]    rows;

  // target = 4 + level*step/25 + wobble - 3, clamped; wobble is 3 when wobble_en is off
  always_comb begin
    scaled     = 9'(ctl.level * STEP);
    lift_prod  = 21'(scaled) * 21'd2622;
    lift       = lift_prod[20:16];
    phase_sum  = {1'b0, ctl.phase} + {1'b0, OFFSET};
    wobble     = (phase_sum >= 4'd7) ? 3'(phase_sum - 4'd7) : phase_sum[2:0];
    target_raw = 5'(MIN_H) + lift + (ctl.wobble_en ? {2'b00, wobble} : 5'd3);
    target_sub = target_raw - 5'd3;
    if (target_sub < 5'(MIN_H)) begin
      target_next = 5'(MIN_H);
    end else if (target_sub > 5'(MAX_H)) begin
      target_next = 5'(MAX_H);
    end else begin
      target_next = target_sub;
    end
  end

  // fast attack, slow decay
  always_comb begin
    rise      = 5'((target - bar + 5'd1) >> 1);
    fall_num  = bar - target + 5'd2;
    fall_prod = 8'(fall_num) * 8'd11;
    if (target > bar) begin
      bar_next = bar + rise;
    end else if (target < bar) begin
      bar_next = bar - {2'b00, fall_prod[7:5]};
    end else begin
      bar_next = bar;
    end
  end

  // rows = 1 + ((bar-4)*(DOT_ROWS-1) + 10) / 20, saturated at 7
  always_comb begin
    height_off = bar - 5'(MIN_H);
    mval       = MW'(int'(height_off) * (DOT_ROWS - 1) + (MAX_H - MIN_H) / 2);
    yval       = mval[MW-1:2];
    qprod      = PW'(yval) * PW'(205);
    rows_full  = 5'(qprod[PW-1:10]) + 5'd1;
    rows       = (rows_full > 5'd7) ? 3'd7 : rows_full[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      bar <= 5'(MIN_H);
    end else if (ctl.update) begin
      bar <= bar_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tgt_en) begin
      target <= target_next;
    end
    if (ctl.load) begin
      rows_out <= rows;
    end else if (ctl.shift) begin
      rows_out <= rows_in;
    end
  end

endmodule

@@ src/dmvu_ctrl.sv @@
// Request decode, level and visibility state, tick sequencing and badge fields.
// Depends on dmvu_pkg; drives the column cells through cell_ctl_t.
module dmvu_ctrl
  import dmvu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  level_percent,
  input  logic        is_voiced,
  input  logic [31:0] now_ms,
  input  logic        stale_limit_we,
  input  logic [15:0] stale_limit_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  column_index,
  output logic        peak_accent,
  output logic        badge_active,
  output logic [7:0]  badge_opacity,
  output logic [1:0]  icon_frame,
  output logic        last_column,
  output cell_ctl_t   ctl
);

  localparam logic [1:0] ACT_LEVEL = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_SHOW  = 2'd2;
  localparam logic [1:0] ACT_HIDE  = 2'd3;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_SHOW = 2'd1;
  localparam logic [1:0] REQ_HIDE = 2'd2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT  = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [2:0] LAST_COL = 3'(COLUMNS - 1);

  logic [2:0]  state;
  logic [15:0] stale_limit;
  logic [6:0]  held_level;
  logic        held_voiced;
  logic [31:0] level_stamp;
  logic        stamp_valid;
  logic [1:0]  pending;
  logic        shown;
  logic [2:0]  tick_mod_seven;
  logic [1:0]  tick_mod_three;
  logic [6:0]  eff_level;
  logic        eff_voiced;
  logic [2:0]  col;

  logic        accept;
  logic        tick;
  logic        shown_next;
  logic        stale;
  logic [31:0] age;
  logic [2:0]  t7_base;
  logic [1:0]  t3_base;
  logic [22:0] opa_prod;

  assign accept = in_valid && in_ready;
  assign tick   = accept && (action == ACT_TICK);

  always_comb begin
    case (pending)
      REQ_SHOW: shown_next = 1'b1;
      REQ_HIDE: shown_next = 1'b0;
      default:  shown_next = shown;
    endcase
    age      = now_ms - level_stamp;
    stale    = !stamp_valid || (age > {16'd0, stale_limit});
    t7_base  = (pending == REQ_SHOW) ? 3'd0 : tick_mod_seven;
    t3_base  = (pending == REQ_SHOW) ? 2'd0 : tick_mod_three;
    opa_prod = 23'(eff_level) * 23'd34086;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stale_limit    <= 16'd280;
      held_level     <= 7'd0;
      held_voiced    <= 1'b0;
      level_stamp    <= 32'd0;
      stamp_valid    <= 1'b0;
      pending        <= REQ_NONE;
      shown          <= 1'b0;
      tick_mod_seven <= 3'd0;
      tick_mod_three <= 2'd0;
      col            <= 3'd0;
    end else begin
      if (stale_limit_we) begin
        stale_limit <= stale_limit_ms;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_LEVEL: begin
                held_level  <= (level_percent > 8'd100) ? 7'd100 : level_percent[6:0];
                held_voiced <= is_voiced;
                level_stamp <= now_ms;
                stamp_valid <= 1'b1;
              end
              ACT_SHOW: pending <= REQ_SHOW;
              ACT_HIDE: pending <= REQ_HIDE;
              default: begin
                pending <= REQ_NONE;
                shown   <= shown_next;
                if (pending == REQ_HIDE) begin
                  held_level  <= 7'd0;
                  held_voiced <= 1'b0;
                  stamp_valid <= 1'b0;
                end
                if (shown_next) begin
                  tick_mod_seven <= (t7_base == 3'd6) ? 3'd0 : t7_base + 3'd1;
                  tick_mod_three <= (t3_base == 2'd2) ? 2'd0 : t3_base + 2'd1;
                  state          <= S_TGT;
                end
              end
            endcase
          end
        end
        S_TGT:  state <= S_MOVE;
        S_MOVE: state <= S_LOAD;
        S_LOAD: begin
          col   <= 3'd0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            col <= col + 3'd1;
            if (col == LAST_COL) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // effective level latched at the tick; hide never reaches here
  always_ff @(posedge clk) begin
    if (tick && shown_next) begin
      eff_level  <= stale ? 7'd0 : held_level;
      eff_voiced <= stale ? 1'b0 : held_voiced;
    end
    if (state == S_TGT) begin
      badge_opacity <= eff_voiced ? 8'd48 + {2'b00, opa_prod[21:16]} : 8'd51;
    end
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_EMIT);
    column_index  = col;
    last_column   = (col == LAST_COL);
    peak_accent   = eff_voiced;
    badge_active  = eff_voiced;
    icon_frame    = eff_voiced ? tick_mod_three + 2'd1 : 2'd0;
    ctl.clear     = tick && (pending == REQ_SHOW);
    ctl.tgt_en    = (state == S_TGT);
    ctl.update    = (state == S_MOVE);
    ctl.load      = (state == S_LOAD);
    ctl.shift     = out_valid && out_ready;
    ctl.wobble_en = (eff_level > 7'd3);
    ctl.level     = eff_level;
    ctl.phase     = tick_mod_seven;
  end

`ifndef ASSERT_OFF
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during emission");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_column) |=> in_ready)
    else $error("no return to idle after last column");

  a_first_column_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (column_index == 3'd0)) else $error("tick starts mid-row");

  a_unvoiced_static_icon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !peak_accent) |-> (icon_frame == 2'd0 && badge_opacity == 8'd51))
    else $error("unvoiced badge fields wrong");
`endif

endmodule

@@ src/dot_matrix_vu_meter.sv @@
// Top level of the dot-matrix VU meter: controller plus a chain of column cells.
// Depends on dmvu_pkg, dmvu_ctrl and dmvu_cell.
//
// A level, show or hide request produces no result.
// A tick taken while the meter is shown produces seven column results, left to
// right; after the request is taken, the S_TGT, S_MOVE and S_LOAD states compute
// targets, bar heights and row counts in all seven cells at once, then the results
// shift out of the cell chain one per cycle while out_ready is high. No new
// request is taken until the last column result of a tick is accepted.
// Configuration writes take effect on the next cycle.
module dot_matrix_vu_meter
  import dmvu_pkg::*;
#(
  parameter int DOT_ROWS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  level_percent,
  input  logic        is_voiced,
  input  logic [31:0] now_ms,
  input  logic        stale_limit_we,
  input  logic [15:0] stale_limit_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  column_index,
  output logic [2:0]  lit_count,
  output logic        peak_accent,
  output logic        badge_active,
  output logic [7:0]  badge_opacity,
  output logic [1:0]  icon_frame,
  output logic        last_column
);

  cell_ctl_t  ctl;
  logic [2:0] rows_chain [COLUMNS+1];

  dmvu_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .level_percent  (level_percent),
    .is_voiced      (is_voiced),
    .now_ms         (now_ms),
    .stale_limit_we (stale_limit_we),
    .stale_limit_ms (stale_limit_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .column_index   (column_index),
    .peak_accent    (peak_accent),
    .badge_active   (badge_active),
    .badge_opacity  (badge_opacity),
    .icon_frame     (icon_frame),
    .last_column    (last_column),
    .ctl            (ctl)
  );

  assign rows_chain[COLUMNS] = 3'd0;

  for (genvar i = 0; i < COLUMNS; i++) begin : g_col
    dmvu_cell #(
      .COL      (i),
      .DOT_ROWS (DOT_ROWS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .rows_in  (rows_chain[i+1]),
      .rows_out (rows_chain[i])
    );
  end

  assign lit_count = rows_chain[0];

endmodule
